@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent a fixed number of cycles after the antecedent
`define ASSERT_DELAY(label, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

@@ rtl/ttmc_pkg.sv @@
`default_nettype none

package ttmc_pkg;

    // fixed field widths of the item, result and configuration
    localparam int RowW     = 5;
    localparam int ColW     = 5;
    localparam int ValueW   = 12;
    localparam int TolW     = 7;
    localparam int TiuW     = 2;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 7;
    localparam int CountW   = 11;

    localparam logic [CountW-1:0] CountMax = '1;
    localparam logic [TolW-1:0]   TolReset = 7'd20;
    localparam logic [TiuW-1:0]   TiuReset = 2'd2;
    localparam int PctScale = 100;

    // result queue
    localparam int ResultDepth = 8;
    localparam int RqPtrW      = 3;
    localparam int RqCntW      = 4;

    // parameter defaults
    localparam int MaxTemplatesDef = 2;
    localparam int RowsDef         = 32;
    localparam int ColsDef         = 32;
    localparam int SampleBitsDef   = 12;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } opcode_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TOLERANCE = 1'b0,
        CFG_TEMPLATES = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic              best_template;
        logic [CountW-1:0] best_count;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/ttmc_in_if.sv @@
`default_nettype none

interface ttmc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic                        template_index;
    logic [ttmc_pkg::RowW-1:0]   row;
    logic [ttmc_pkg::ColW-1:0]   col;
    logic [ttmc_pkg::ValueW-1:0] value;
    logic                        last_cell;

    modport source (
        output valid, opcode, template_index, row, col, value, last_cell,
        input  ready
    );
    modport sink (
        input  valid, opcode, template_index, row, col, value, last_cell,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/ttmc_out_if.sv @@
`default_nettype none

interface ttmc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        best_template;
    logic [ttmc_pkg::CountW-1:0] best_count;

    modport source (
        output valid, best_template, best_count,
        input  ready
    );
    modport sink (
        input  valid, best_template, best_count,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/tolerance_template_match_classifier.sv @@
// path: the result channel offers a result once the item with last_cell has passed
//   memory read, abs difference and product, compare, count, vote and the result queue
// throughput: one item per cycle; input stalls only when the 8-entry result queue plus
//   results still in the pipeline would overflow
// reset: config registers load their defaults, match counters and all valid bits clear at once; the
//   template store has no reset and holds garbage until loaded
`default_nettype none

`include "assert_macros.svh"

module tolerance_template_match_classifier #(
    parameter int MAX_TEMPLATES = ttmc_pkg::MaxTemplatesDef,
    parameter int ROWS          = ttmc_pkg::RowsDef,
    parameter int COLS          = ttmc_pkg::ColsDef,
    parameter int SAMPLE_BITS   = ttmc_pkg::SampleBitsDef
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ttmc_in_if.sink                        in_item,
    ttmc_out_if.source                     result,
    input  logic                           cfg_we,
    input  logic [ttmc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ttmc_pkg::CfgDataW-1:0]  cfg_wdata
);

    localparam int CELLS   = ROWS * COLS;
    localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PROD_W  = SAMPLE_BITS + ttmc_pkg::TolW;
    localparam int TP      = 1 << $clog2(MAX_TEMPLATES);
    localparam int LEVELS  = $clog2(TP);
    localparam int IDX_W   = (TP > 1) ? $clog2(TP) : 1;
    localparam int COUNT_W = ttmc_pkg::CountW;
    localparam int SUM_W   = ttmc_pkg::RqCntW + 1;

    // configuration
    logic [ttmc_pkg::TolW-1:0] tol_reg;
    logic [ttmc_pkg::TiuW-1:0] tiu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= ttmc_pkg::TolReset;
            tiu_reg <= ttmc_pkg::TiuReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ttmc_pkg::CFG_TOLERANCE: tol_reg <= cfg_wdata;
                ttmc_pkg::CFG_TEMPLATES: tiu_reg <= cfg_wdata[ttmc_pkg::TiuW-1:0];
                default: ;
            endcase
        end
    end

    // lane t takes part when t is below the clamped template count
    logic lane_active [MAX_TEMPLATES];
    always_comb
    begin
        for (int t = 0; t < MAX_TEMPLATES; t++)
            lane_active[t] = (t == 0) || (32'(tiu_reg) > 32'(t));
    end

    // input decode
    logic                   in_fire;
    logic                   is_sample;
    logic                   in_grid;
    logic                   load_ok;
    logic [CELL_W-1:0]      cell_addr;
    logic [SAMPLE_BITS-1:0] meas_in;

    assign in_fire   = in_item.valid && in_item.ready;
    assign is_sample = (in_item.opcode == ttmc_pkg::OP_SAMPLE);
    assign in_grid   = (32'(in_item.row) < 32'(ROWS)) && (32'(in_item.col) < 32'(COLS));
    assign cell_addr = CELL_W'(32'(in_item.row) * 32'(COLS) + 32'(in_item.col));
    assign meas_in   = SAMPLE_BITS'(in_item.value);
    assign load_ok   = in_fire && !is_sample && in_grid
                       && (32'(in_item.template_index) < 32'(MAX_TEMPLATES));

    // template store: one lane memory per template, all read at the same cell
    logic [SAMPLE_BITS-1:0] rd_data_reg [MAX_TEMPLATES];

    for (genvar t = 0; t < MAX_TEMPLATES; t++)
    begin : g_lane
        logic [SAMPLE_BITS-1:0] template_store [CELLS];

        always_ff @(posedge clk)
        begin
            if (load_ok && (32'(in_item.template_index) == 32'(t)))
                template_store[cell_addr] <= meas_in;
            if (in_fire)
                rd_data_reg[t] <= template_store[cell_addr];
        end
    end

    // stage 1: read data arrives
    logic                   s1_count_reg, s1_last_reg;
    logic [SAMPLE_BITS-1:0] s1_meas_reg;
    // stage 2: product and per-lane distance
    logic                   s2_count_reg, s2_last_reg;
    logic [PROD_W-1:0]      s2_prod_reg;
    logic [SAMPLE_BITS-1:0] s2_diff_reg [MAX_TEMPLATES];
    // stage 3: per-lane match
    logic                   s3_last_reg;
    logic                   s3_match_reg [MAX_TEMPLATES];
    // stage 4: counters and frame snapshot
    logic [COUNT_W-1:0]     cnt_reg [MAX_TEMPLATES];
    logic [COUNT_W-1:0]     cnt_upd [MAX_TEMPLATES];
    logic [COUNT_W-1:0]     snap_next [TP];
    logic [COUNT_W-1:0]     snap_reg [TP];
    logic                   snap_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_count_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            s2_count_reg   <= 1'b0;
            s2_last_reg    <= 1'b0;
            s3_last_reg    <= 1'b0;
            snap_valid_reg <= 1'b0;
            for (int t = 0; t < MAX_TEMPLATES; t++)
            begin
                s3_match_reg[t] <= 1'b0;
                cnt_reg[t]      <= '0;
            end
        end
        else
        begin
            s1_count_reg   <= in_fire && is_sample && in_grid;
            s1_last_reg    <= in_fire && is_sample && in_item.last_cell;
            s2_count_reg   <= s1_count_reg;
            s2_last_reg    <= s1_last_reg;
            s3_last_reg    <= s2_last_reg;
            snap_valid_reg <= s3_last_reg;
            for (int t = 0; t < MAX_TEMPLATES; t++)
            begin
                // inside tolerance iff 100 * (|t - m| + 1) <= m * pct
                s3_match_reg[t] <= s2_count_reg && lane_active[t]
                    && (((PROD_W'(s2_diff_reg[t]) + PROD_W'(1)) * PROD_W'(ttmc_pkg::PctScale))
                        <= s2_prod_reg);
                cnt_reg[t] <= s3_last_reg ? COUNT_W'(0) : cnt_upd[t];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_meas_reg <= meas_in;
        s2_prod_reg <= PROD_W'(s1_meas_reg) * PROD_W'(tol_reg);
        for (int t = 0; t < MAX_TEMPLATES; t++)
        begin
            s2_diff_reg[t] <= (s1_meas_reg >= rd_data_reg[t]) ? (s1_meas_reg - rd_data_reg[t])
                                                              : (rd_data_reg[t] - s1_meas_reg);
        end
        if (s3_last_reg)
        begin
            for (int t = 0; t < TP; t++)
                snap_reg[t] <= snap_next[t];
        end
    end

    always_comb
    begin
        for (int t = 0; t < MAX_TEMPLATES; t++)
        begin
            cnt_upd[t] = cnt_reg[t]
                         + COUNT_W'(s3_match_reg[t] && (cnt_reg[t] != ttmc_pkg::CountMax));
        end
    end

    for (genvar t = 0; t < TP; t++)
    begin : g_snap
        if (t < MAX_TEMPLATES)
        begin : g_used
            assign snap_next[t] = lane_active[t] ? cnt_upd[t] : COUNT_W'(0);
        end
        else
        begin : g_pad
            assign snap_next[t] = '0;
        end
    end

    // stage 5: vote tree, the right side wins only with a strictly greater count
    logic [COUNT_W-1:0] v_cnt [TP];
    logic [IDX_W-1:0]   v_idx [TP];

    always_comb
    begin
        for (int i = 0; i < TP; i++)
        begin
            v_cnt[i] = snap_reg[i];
            v_idx[i] = IDX_W'(i);
        end
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int i = 0; i < TP; i += (2 << l))
            begin
                if (v_cnt[i + (1 << l)] > v_cnt[i])
                begin
                    v_cnt[i] = v_cnt[i + (1 << l)];
                    v_idx[i] = v_idx[i + (1 << l)];
                end
            end
        end
    end

    // result queue
    ttmc_pkg::result_t                 rq_reg [ttmc_pkg::ResultDepth];
    logic [ttmc_pkg::RqPtrW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [ttmc_pkg::RqCntW-1:0]       rq_cnt_reg;
    logic                              push, pop;
    logic [2:0]                        inflight;
    logic [SUM_W-1:0]                  committed;

    assign push = snap_valid_reg;
    assign pop  = result.valid && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            rq_cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + ttmc_pkg::RqPtrW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + ttmc_pkg::RqPtrW'(1);
            rq_cnt_reg <= rq_cnt_reg + ttmc_pkg::RqCntW'(push) - ttmc_pkg::RqCntW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rq_reg[wr_ptr_reg].best_template <= v_idx[0][0];
            rq_reg[wr_ptr_reg].best_count    <= v_cnt[0];
        end
    end

    assign inflight = 3'(s1_last_reg) + 3'(s2_last_reg) + 3'(s3_last_reg)
                      + 3'(snap_valid_reg);

    // room for every result that may still come out of the pipeline
    assign committed     = SUM_W'(rq_cnt_reg) + SUM_W'(inflight);
    assign in_item.ready = committed < SUM_W'(ttmc_pkg::ResultDepth);

    assign result.valid         = (rq_cnt_reg != '0);
    assign result.best_template = rq_reg[rd_ptr_reg].best_template;
    assign result.best_count    = rq_reg[rd_ptr_reg].best_count;

    `ASSERT_ALWAYS(a_no_overrun, committed <= SUM_W'(ttmc_pkg::ResultDepth),
        "result queue overcommitted")
    `ASSERT_IMPLIES(a_push_room, push,
        (rq_cnt_reg != ttmc_pkg::RqCntW'(ttmc_pkg::ResultDepth)) || pop, "push into full queue")
    `ASSERT_DELAY(a_last_to_vote, s1_last_reg, 3, snap_valid_reg, "frame end lost in pipeline")
    `ASSERT_DELAY(a_counters_clear, s3_last_reg, 1, cnt_reg[0] == COUNT_W'(0),
        "counter not cleared at frame end")

endmodule

`default_nettype wire
